// ===== design/payload_decrypt_verify_unit_macros.svh =====
`ifndef PAYLOAD_DECRYPT_VERIFY_UNIT_MACROS_SVH
`define PAYLOAD_DECRYPT_VERIFY_UNIT_MACROS_SVH

// checked outside reset
`define PDV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define PDV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/pdv_pkg.sv =====
package pdv_pkg;

  typedef struct packed {
    logic [7:0] enc_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       byte_valid;
    logic       final_res;
    logic [1:0] status;
  } out_word_t;

  // front to back
  typedef struct packed {
    logic [7:0] plain;
    logic       in_win;
    logic       last;
    logic       short_strm;
  } mid_word_t;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned POS_W     = 33;
  localparam int unsigned JUNK_W    = 6;

  localparam logic [REG_IDX_W-1:0] REG_SEED     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAY_SIZE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EXP_CHK  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TRUNC    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  localparam logic [63:0]      KEY_SEED_MIX = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [16:0]      ADLER_MOD    = 17'd65521;
  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

  function automatic logic [63:0] xorshift64(logic [63:0] x);
    logic [63:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 7);
    y = y ^ (y << 17);
    return y;
  endfunction

endpackage

// ===== design/payload_decrypt_verify_unit.sv =====
// Streaming payload decryptor and Adler-32 verifier. One encrypted byte per
// pushed word is XORed with a repeating KEY_BYTES key built from xorshift64
// words (generated while the first KEY_BYTES bytes pass), the junk prefix set
// by seed[5:0] is marked invalid, the next payload_size bytes come out with
// byte_valid set and are summed, and the word with last set carries the
// status (ok, truncated, checksum mismatch) and starts a new stream. Every
// pushed word yields exactly one result word. Throughput is one word per
// clock while the result side is popped; a pushed word is registered in a
// two-entry queue between the key/classify front and the checksum back, and
// then in the output register. Write the registers only while no words are
// in flight.
module payload_decrypt_verify_unit #(
  parameter int unsigned KEY_BYTES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  pdv_pkg::in_word_t             in_data_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output pdv_pkg::out_word_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pdv_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [pdv_pkg::CFG_W-1:0]     cfg_wdata_i
);

  logic [pdv_pkg::CFG_W-1:0] seed_q, size_q, chk_q;
  pdv_pkg::mid_word_t        front_word, back_word;
  logic                      take, mid_empty, mid_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      size_q <= '0;
      chk_q  <= 32'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pdv_pkg::REG_SEED:     seed_q <= cfg_wdata_i;
        pdv_pkg::REG_PAY_SIZE: size_q <= cfg_wdata_i;
        pdv_pkg::REG_EXP_CHK:  chk_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign take = push_i && !full_o;

  pdv_front #(
    .KEY_BYTES(KEY_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .in_word_i  (in_data_i),
    .seed_i     (seed_q),
    .pay_size_i (size_q),
    .mid_o      (front_word)
  );

  pdv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .data_i  (front_word),
    .full_o  (full_o),
    .pop_i   (mid_pop),
    .data_o  (back_word),
    .empty_o (mid_empty)
  );

  pdv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_i       (back_word),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .exp_chk_i   (chk_q),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_o       (out_data_o)
  );

endmodule

// ===== design/pdv_front.sv =====
module pdv_front #(
  parameter int unsigned KEY_BYTES = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  pdv_pkg::in_word_t         in_word_i,
  input  logic [pdv_pkg::CFG_W-1:0] seed_i,
  input  logic [pdv_pkg::CFG_W-1:0] pay_size_i,
  output pdv_pkg::mid_word_t        mid_o
);

  localparam int unsigned KIDX_W    = $clog2(KEY_BYTES);
  localparam int unsigned KEY_WORDS = (KEY_BYTES + 7) / 8;
  localparam int unsigned WIDX_W    = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_BYTES - 1);

  logic [pdv_pkg::POS_W-1:0] pos_q, pos_d;
  logic [KIDX_W-1:0]         kidx_q, kidx_d;
  logic [63:0]               kgen_q;
  logic [63:0]               key_q [KEY_WORDS];

  logic [63:0]               gen_state, gen_word, key_word;
  logic [2:0]                bsel;
  logic [WIDX_W-1:0]         widx;
  logic                      do_gen;
  logic [7:0]                key_byte, plain;
  logic [pdv_pkg::POS_W-1:0] junk, end_pos;
  logic                      in_win;

  always_comb begin
    gen_state = (pos_q == '0) ? ({32'b0, seed_i} ^ pdv_pkg::KEY_SEED_MIX) : kgen_q;
    gen_word  = pdv_pkg::xorshift64(gen_state);
    bsel      = kidx_q[2:0];
    widx      = WIDX_W'(kidx_q >> 3);
    do_gen    = (pos_q < pdv_pkg::POS_W'(KEY_BYTES)) && (bsel == 3'd0);
    key_word  = do_gen ? gen_word : key_q[widx];
    key_byte  = key_word[{bsel, 3'b000} +: 8];
    plain     = in_word_i.enc_byte ^ key_byte;
    junk      = pdv_pkg::POS_W'(seed_i[pdv_pkg::JUNK_W-1:0]);
    end_pos   = junk + pdv_pkg::POS_W'(pay_size_i);
    in_win    = (pos_q >= junk) && (pos_q < end_pos);

    mid_o.plain      = in_win ? plain : 8'h00;
    mid_o.in_win     = in_win;
    mid_o.last       = in_word_i.last;
    mid_o.short_strm = ({1'b0, pos_q} + 34'd1) < {1'b0, end_pos};

    pos_d  = pos_q;
    kidx_d = kidx_q;
    if (in_word_i.last) begin
      pos_d  = '0;
      kidx_d = '0;
    end else if (pos_q != pdv_pkg::POS_MAX) begin
      pos_d  = pos_q + pdv_pkg::POS_W'(1);
      kidx_d = (kidx_q == KIDX_LAST) ? '0 : kidx_q + KIDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      kidx_q <= '0;
    end else if (take_i) begin
      pos_q  <= pos_d;
      kidx_q <= kidx_d;
    end
  end

  // key words and generator state are always written before use
  always_ff @(posedge clk_i) begin
    if (take_i && do_gen) begin
      kgen_q      <= gen_word;
      key_q[widx] <= gen_word;
    end
  end

endmodule

// ===== design/pdv_fifo.sv =====
module pdv_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pdv_pkg::mid_word_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output pdv_pkg::mid_word_t data_o,
  output logic               empty_o
);

  pdv_pkg::mid_word_t mem_q [2];
  logic               wr_q, rd_q;
  logic [1:0]         cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== design/pdv_back.sv =====
module pdv_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pdv_pkg::mid_word_t        mid_i,
  input  logic                      mid_empty_i,
  output logic                      mid_pop_o,
  input  logic [pdv_pkg::CFG_W-1:0] exp_chk_i,
  input  logic                      pop_i,
  output logic                      empty_o,
  output pdv_pkg::out_word_t        out_o
);

  logic               out_vld_q;
  pdv_pkg::out_word_t out_q, out_d;
  logic [15:0]        lo_q, hi_q, lo_n, hi_n;
  logic [16:0]        lo_sum, hi_sum;
  logic               take;

  assign take      = !mid_empty_i && (!out_vld_q || pop_i);
  assign mid_pop_o = take;
  assign empty_o   = !out_vld_q;
  assign out_o     = out_q;

  always_comb begin
    lo_sum = {1'b0, lo_q} + {9'b0, mid_i.plain};
    lo_n   = (lo_sum >= pdv_pkg::ADLER_MOD) ? 16'(lo_sum - pdv_pkg::ADLER_MOD)
                                            : lo_sum[15:0];
    hi_sum = {1'b0, hi_q} + {1'b0, lo_n};
    hi_n   = (hi_sum >= pdv_pkg::ADLER_MOD) ? 16'(hi_sum - pdv_pkg::ADLER_MOD)
                                            : hi_sum[15:0];
    if (!mid_i.in_win) begin
      lo_n = lo_q;
      hi_n = hi_q;
    end

    out_d.plain_byte = mid_i.plain;
    out_d.byte_valid = mid_i.in_win;
    out_d.final_res  = mid_i.last;
    out_d.status     = pdv_pkg::ST_OK;
    if (mid_i.last) begin
      if (mid_i.short_strm)             out_d.status = pdv_pkg::ST_TRUNC;
      else if ({hi_n, lo_n} != exp_chk_i) out_d.status = pdv_pkg::ST_MISMATCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      lo_q      <= 16'd1;
      hi_q      <= 16'd0;
    end else begin
      if (take) begin
        out_vld_q <= 1'b1;
        if (mid_i.last) begin
          lo_q <= 16'd1;
          hi_q <= 16'd0;
        end else begin
          lo_q <= lo_n;
          hi_q <= hi_n;
        end
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= out_d;
  end

endmodule

// ===== design/pdv_checker.sv =====
`include "payload_decrypt_verify_unit_macros.svh"

module pdv_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty_o,
  input logic               pop_i,
  input pdv_pkg::out_word_t out_data_o
);

  logic waiting, shown_mid, shown_junk;

  assign waiting    = !empty_o && !pop_i;
  assign shown_mid  = !empty_o && !out_data_o.final_res;
  assign shown_junk = !empty_o && !out_data_o.byte_valid;

  `PDV_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> empty_o, "result side not empty in reset")

  `PDV_ASSERT(a_hold, waiting |=> (!empty_o && $stable(out_data_o)), "word changed while waiting")

  `PDV_ASSERT(a_status_final, shown_mid |-> (out_data_o.status == pdv_pkg::ST_OK), "bad status")

  `PDV_ASSERT(a_junk_zero, shown_junk |-> (out_data_o.plain_byte == 8'h00), "junk carries data")

endmodule

bind payload_decrypt_verify_unit pdv_checker u_pdv_checker (.*);
